/* hdl/pfgt_pkg.sv */
// Package for the Pauli frame gate tracker: sizes, operation codes,
// item structs and the control struct shared by the top level and its lanes.
// No dependencies.
package pfgt_pkg;

  localparam int unsigned NUM_QUBITS = 64;
  localparam int unsigned SHOT_COUNT = 64;
  localparam int unsigned QW         = 6;   // qubit and shot field width
  localparam int unsigned WORD_W     = 64;  // shot word width
  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned LANE_W     = WORD_W / NUM_LANES;

  typedef enum logic [3:0] {
    K_FLIP = 4'd0,
    K_H    = 4'd1,
    K_S    = 4'd2,
    K_SX   = 4'd3,
    K_CX   = 4'd4,
    K_CZ   = 4'd5,
    K_SXX  = 4'd6,
    K_SZZ  = 4'd7,
    K_MX   = 4'd8,
    K_MZ   = 4'd9,
    K_RX   = 4'd10,
    K_RZ   = 4'd11
  } kind_e;

  typedef struct packed {
    logic [3:0]    kind;
    logic [QW-1:0] qubit_a;
    logic [QW-1:0] qubit_b;
    logic [QW-1:0] shot_index;
    logic [1:0]    error_type;
    logic [15:0]   meas_tag;
  } in_item_t;

  typedef struct packed {
    logic [QW-1:0]     out_qubit;
    logic [15:0]       out_tag;
    logic [WORD_W-1:0] flip_mask;
  } out_item_t;

  // Control from the sequencer to every lane.
  typedef struct packed {
    kind_e         kind;
    logic          rd_en;
    logic [QW-1:0] rd_addr_a;
    logic [QW-1:0] rd_addr_b;
    logic          va;       // row a has been written since reset
    logic          vb;       // row b has been written since reset
    logic          we;
    logic [QW-1:0] waddr;
    logic          wsel_b;   // write the b-row results
  } lane_ctrl_t;

endpackage

/* hdl/pauli_frame_gate_tracker.sv */
// Pauli frame gate tracker, top level: sequencer, row valid bits, four shot
// lanes and the merging output stage. Depends on pfgt_pkg, pfgt_lane, pfgt_merge.
// In IDLE an item is taken and its frame rows are read. One-qubit
// ops write row a in CALC; valid two-qubit gates also write row b in WRB,
// since each lane memory has one write port and rows a and b are written in
// turn. A measurement loads its result item into the output register in
// CALC; a measurement waits in CALC while the output is full.
// Reset (async, active low) clears the state machine, output valid and the
// per-qubit valid bits, so every frame reads as zero right after reset.
module pauli_frame_gate_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pfgt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pfgt_pkg::out_item_t  out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_WRB  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Item being worked on, plus decoded qualifiers.
  pfgt_pkg::in_item_t op_q;
  logic               a_ok_q, two_q, shot_ok_q;
  logic               va_q, vb_q;

  // One bit per qubit row: set once the row has been written.
  logic [pfgt_pkg::NUM_QUBITS-1:0] row_valid_q;

  logic                accept;
  logic                a_ok, b_ok;
  pfgt_pkg::kind_e     kind;
  logic                is_meas, wr_a, wr_b;
  logic                load, load_ready;
  pfgt_pkg::lane_ctrl_t ctrl;

  logic [pfgt_pkg::WORD_W-1:0] flip_word, flip_x, flip_z;
  logic [pfgt_pkg::NUM_LANES*pfgt_pkg::LANE_W-1:0] lane_mask;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign a_ok = ({1'b0, in_item_i.qubit_a} < (pfgt_pkg::QW+1)'(pfgt_pkg::NUM_QUBITS));
  assign b_ok = ({1'b0, in_item_i.qubit_b} < (pfgt_pkg::QW+1)'(pfgt_pkg::NUM_QUBITS));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= in_item_i;
      a_ok_q    <= a_ok;
      two_q     <= a_ok && b_ok && (in_item_i.qubit_a != in_item_i.qubit_b);
      shot_ok_q <= ({1'b0, in_item_i.shot_index}
                    < (pfgt_pkg::QW+1)'(pfgt_pkg::SHOT_COUNT));
      va_q      <= a_ok && row_valid_q[in_item_i.qubit_a];
      vb_q      <= b_ok && row_valid_q[in_item_i.qubit_b];
    end
  end

  assign kind = pfgt_pkg::kind_e'(op_q.kind);

  // Which rows the current op writes back.
  always_comb begin
    is_meas = 1'b0;
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    unique case (kind) inside
      pfgt_pkg::K_FLIP, pfgt_pkg::K_H, pfgt_pkg::K_S, pfgt_pkg::K_SX,
      pfgt_pkg::K_RX, pfgt_pkg::K_RZ: wr_a = a_ok_q;
      pfgt_pkg::K_CX, pfgt_pkg::K_CZ, pfgt_pkg::K_SXX, pfgt_pkg::K_SZZ: begin
        wr_a = two_q;
        wr_b = two_q;
      end
      pfgt_pkg::K_MX, pfgt_pkg::K_MZ: is_meas = 1'b1;
      default: ;
    endcase
  end

  // Error injection: one shot bit, on X and/or Z.
  assign flip_word = (a_ok_q && shot_ok_q)
                   ? (pfgt_pkg::WORD_W'(1) << op_q.shot_index) : '0;
  assign flip_x = flip_word & {pfgt_pkg::WORD_W{op_q.error_type[0]}};
  assign flip_z = flip_word & {pfgt_pkg::WORD_W{op_q.error_type[1]}};

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_CALC;
      S_CALC: begin
        if (is_meas) begin
          load = 1'b1;
          if (load_ready) state_d = S_IDLE;
        end else if (wr_b) begin
          state_d = S_WRB;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WRB: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Lane control: read at accept, write row a in CALC and row b in WRB.
  always_comb begin
    ctrl.kind      = kind;
    ctrl.rd_en     = accept;
    ctrl.rd_addr_a = in_item_i.qubit_a;
    ctrl.rd_addr_b = in_item_i.qubit_b;
    ctrl.va        = va_q;
    ctrl.vb        = vb_q;
    ctrl.we        = ((state_q == S_CALC) && wr_a) || (state_q == S_WRB);
    ctrl.wsel_b    = (state_q == S_WRB);
    ctrl.waddr     = ctrl.wsel_b ? op_q.qubit_b : op_q.qubit_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (ctrl.we) begin
      row_valid_q[ctrl.waddr] <= 1'b1;
    end
  end

  for (genvar l = 0; l < pfgt_pkg::NUM_LANES; l++) begin : g_lane
    pfgt_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .flip_x_i (flip_x[l*pfgt_pkg::LANE_W +: pfgt_pkg::LANE_W]),
      .flip_z_i (flip_z[l*pfgt_pkg::LANE_W +: pfgt_pkg::LANE_W]),
      .mask_o   (lane_mask[l*pfgt_pkg::LANE_W +: pfgt_pkg::LANE_W])
    );
  end

  pfgt_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .load_ready_o (load_ready),
    .qubit_i      (op_q.qubit_a),
    .tag_i        (op_q.meas_tag),
    .lane_mask_i  (lane_mask),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  // Row b is written only right after row a of a valid two-qubit gate.
  a_wrb_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRB) |-> $past(state_q == S_CALC))
    else $error("row b write without preceding row a write");

  a_wrb_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRB) |-> (op_q.qubit_a != op_q.qubit_b))
    else $error("two-qubit write with equal rows");

  a_out_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_CALC))
    else $error("result item appeared without a measurement");

endmodule

/* hdl/pfgt_lane.sv */
// One lane of the frame store: a slice of the shot word for every qubit,
// X and Z memories with registered reads, and the Pauli update logic.
// Depends on pfgt_pkg.
module pfgt_lane (
  input  logic                         clk_i,
  input  pfgt_pkg::lane_ctrl_t         ctrl_i,
  input  logic [pfgt_pkg::LANE_W-1:0]  flip_x_i,
  input  logic [pfgt_pkg::LANE_W-1:0]  flip_z_i,
  output logic [pfgt_pkg::LANE_W-1:0]  mask_o
);

  logic [pfgt_pkg::LANE_W-1:0] x_mem [pfgt_pkg::NUM_QUBITS];
  logic [pfgt_pkg::LANE_W-1:0] z_mem [pfgt_pkg::NUM_QUBITS];

  logic [pfgt_pkg::LANE_W-1:0] xa_q, za_q, xb_q, zb_q;
  logic [pfgt_pkg::LANE_W-1:0] xa, za, xb, zb, d;
  logic [pfgt_pkg::LANE_W-1:0] nxa, nza, nxb, nzb;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      xa_q <= x_mem[ctrl_i.rd_addr_a];
      za_q <= z_mem[ctrl_i.rd_addr_a];
      xb_q <= x_mem[ctrl_i.rd_addr_b];
      zb_q <= z_mem[ctrl_i.rd_addr_b];
    end
    if (ctrl_i.we) begin
      x_mem[ctrl_i.waddr] <= ctrl_i.wsel_b ? nxb : nxa;
      z_mem[ctrl_i.waddr] <= ctrl_i.wsel_b ? nzb : nza;
    end
  end

  // Rows never written read as zero.
  assign xa = xa_q & {pfgt_pkg::LANE_W{ctrl_i.va}};
  assign za = za_q & {pfgt_pkg::LANE_W{ctrl_i.va}};
  assign xb = xb_q & {pfgt_pkg::LANE_W{ctrl_i.vb}};
  assign zb = zb_q & {pfgt_pkg::LANE_W{ctrl_i.vb}};

  always_comb begin
    nxa = xa;
    nza = za;
    nxb = xb;
    nzb = zb;
    d   = '0;
    case (ctrl_i.kind)
      pfgt_pkg::K_FLIP: begin
        nxa = xa ^ flip_x_i;
        nza = za ^ flip_z_i;
      end
      pfgt_pkg::K_H: begin
        nxa = za;
        nza = xa;
      end
      pfgt_pkg::K_S:  nza = za ^ xa;
      pfgt_pkg::K_SX: nxa = xa ^ za;
      pfgt_pkg::K_CX: begin
        nxb = xb ^ xa;
        nza = za ^ zb;
      end
      pfgt_pkg::K_CZ: begin
        nzb = zb ^ xa;
        nza = za ^ xb;
      end
      pfgt_pkg::K_SXX: begin
        d   = za ^ zb;
        nxa = xa ^ d;
        nxb = xb ^ d;
      end
      pfgt_pkg::K_SZZ: begin
        d   = xa ^ xb;
        nza = za ^ d;
        nzb = zb ^ d;
      end
      pfgt_pkg::K_RX: nza = '0;
      pfgt_pkg::K_RZ: nxa = '0;
      default: ;
    endcase
  end

  // mx reports Z bits, mz reports X bits.
  assign mask_o = (ctrl_i.kind == pfgt_pkg::K_MX) ? za : xa;

endmodule

/* hdl/pfgt_merge.sv */
// Merging stage: joins the lane masks into one shot word and holds the
// measurement result item in an output register. Depends on pfgt_pkg.
module pfgt_merge (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              load_i,
  output logic                                              load_ready_o,
  input  logic [pfgt_pkg::QW-1:0]                           qubit_i,
  input  logic [15:0]                                       tag_i,
  input  logic [pfgt_pkg::NUM_LANES*pfgt_pkg::LANE_W-1:0]   lane_mask_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output pfgt_pkg::out_item_t                               out_item_o
);

  logic                valid_q, valid_d;
  pfgt_pkg::out_item_t item_q;

  assign load_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i && load_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o) begin
      item_q.out_qubit <= qubit_i;
      item_q.out_tag   <= tag_i;
      item_q.flip_mask <= pfgt_pkg::WORD_W'(lane_mask_i);
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
